[hdl/stpf_pkg.sv]
// Shared types and constants for the 3x3 supertower peak finder.
package stpf_pkg;

  localparam int ENERGY_BITS = 12;
  localparam int IDX_BITS    = 2;

  typedef logic [ENERGY_BITS-1:0] energy_t;
  typedef logic [IDX_BITS-1:0]    idx_t;

  localparam idx_t IDX0 = 2'd0;
  localparam idx_t IDX1 = 2'd1;
  localparam idx_t IDX2 = 2'd2;

  typedef struct packed {
    energy_t total;
    idx_t    row;
    idx_t    col;
    energy_t energy;
  } peak_t;

endpackage

[hdl/supertower_3x3_peak_finder_top.sv]
// Top level of the 3x3 supertower peak finder: strip lanes, merge, two-stage pipe.
//
// Input channel: nine 12-bit tower energies (tower_rR_cC) with in_valid/in_ready.
// Output channel: window_total, peak_row, peak_col, peak_energy with
// out_valid/out_ready.
// Six strip lanes sum the three rows and three columns in parallel into
// stage one; the merge stage picks the peak row and column, selects the
// peak tower and forms the total into the output register.
// An accepted beat moves through the stage-one register into the output register.
// Throughput: one window per cycle unless stalled; each stage holds a short add or compare path.
// A stalled receiver holds the output beat; stage one still takes a new
// window while it is empty, and in_ready drops once both stages are full.
// Reset empties both stages; no beat is presented until one is accepted.
module supertower_3x3_peak_finder_top (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  stpf_pkg::energy_t tower_r0_c0,
  input  stpf_pkg::energy_t tower_r0_c1,
  input  stpf_pkg::energy_t tower_r0_c2,
  input  stpf_pkg::energy_t tower_r1_c0,
  input  stpf_pkg::energy_t tower_r1_c1,
  input  stpf_pkg::energy_t tower_r1_c2,
  input  stpf_pkg::energy_t tower_r2_c0,
  input  stpf_pkg::energy_t tower_r2_c1,
  input  stpf_pkg::energy_t tower_r2_c2,
  output logic              out_valid,
  input  logic              out_ready,
  output stpf_pkg::energy_t window_total,
  output stpf_pkg::idx_t    peak_row,
  output stpf_pkg::idx_t    peak_col,
  output stpf_pkg::energy_t peak_energy
);

  stpf_pkg::energy_t e_in    [3][3];
  stpf_pkg::energy_t row_in  [3];
  stpf_pkg::energy_t col_in  [3];
  stpf_pkg::energy_t s1_e    [3][3];
  stpf_pkg::energy_t s1_row  [3];
  stpf_pkg::energy_t s1_col  [3];
  logic              s1_valid;
  logic              s2_adv;
  logic              s1_adv;
  stpf_pkg::peak_t   peak_next;
  stpf_pkg::peak_t   peak;

  assign e_in[0][0] = tower_r0_c0;
  assign e_in[0][1] = tower_r0_c1;
  assign e_in[0][2] = tower_r0_c2;
  assign e_in[1][0] = tower_r1_c0;
  assign e_in[1][1] = tower_r1_c1;
  assign e_in[1][2] = tower_r1_c2;
  assign e_in[2][0] = tower_r2_c0;
  assign e_in[2][1] = tower_r2_c1;
  assign e_in[2][2] = tower_r2_c2;

  for (genvar i = 0; i < 3; i++) begin : g_lane
    stpf_strip_lane u_row (
      .a   (e_in[i][0]),
      .b   (e_in[i][1]),
      .c   (e_in[i][2]),
      .sum (row_in[i])
    );
    stpf_strip_lane u_col (
      .a   (e_in[0][i]),
      .b   (e_in[1][i]),
      .c   (e_in[2][i]),
      .sum (col_in[i])
    );
  end

  assign s2_adv   = !out_valid || out_ready;
  assign s1_adv   = !s1_valid || s2_adv;
  assign in_ready = s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_adv) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && in_valid) begin
      s1_e   <= e_in;
      s1_row <= row_in;
      s1_col <= col_in;
    end
  end

  stpf_merge u_merge (
    .row_sum (s1_row),
    .col_sum (s1_col),
    .e       (s1_e),
    .peak    (peak_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_adv) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv && s1_valid) begin
      peak <= peak_next;
    end
  end

  assign window_total = peak.total;
  assign peak_row     = peak.row;
  assign peak_col     = peak.col;
  assign peak_energy  = peak.energy;

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (peak_row != 2'd3) && (peak_col != 2'd3))
    else $error("peak index out of range");

  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> s1_valid)
    else $error("accepted beat not held in stage one");

  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && out_valid && !out_ready) |=>
      (s1_valid && $stable(s1_row[0]) && $stable(s1_col[0])))
    else $error("stage one lost its beat under stall");

  a_s1_moves: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s2_adv) |=> out_valid)
    else $error("stage one beat did not reach the output");

endmodule

[hdl/stpf_strip_lane.sv]
// One strip lane: wrapped sum of three tower energies.
module stpf_strip_lane (
  input  stpf_pkg::energy_t a,
  input  stpf_pkg::energy_t b,
  input  stpf_pkg::energy_t c,
  output stpf_pkg::energy_t sum
);

  assign sum = stpf_pkg::energy_t'(a + b + c);

endmodule

[hdl/stpf_merge.sv]
// Merge stage: window total, row and column peak pick, peak tower select.
module stpf_merge (
  input  stpf_pkg::energy_t row_sum [3],
  input  stpf_pkg::energy_t col_sum [3],
  input  stpf_pkg::energy_t e       [3][3],
  output stpf_pkg::peak_t   peak
);

  function automatic stpf_pkg::idx_t pick3(input stpf_pkg::energy_t a,
                                           input stpf_pkg::energy_t b,
                                           input stpf_pkg::energy_t c);
    stpf_pkg::idx_t    idx;
    stpf_pkg::energy_t best;
    if (a > b) begin
      idx  = stpf_pkg::IDX0;
      best = a;
    end else begin
      idx  = stpf_pkg::IDX1;
      best = b;
    end
    if (c > best) begin
      idx = stpf_pkg::IDX2;
    end
    return idx;
  endfunction

  stpf_pkg::idx_t    row;
  stpf_pkg::idx_t    col;
  stpf_pkg::energy_t row_e [3];
  stpf_pkg::energy_t sel;

  assign row = pick3(row_sum[0], row_sum[1], row_sum[2]);
  assign col = pick3(col_sum[0], col_sum[1], col_sum[2]);

  always_comb begin
    unique case (row)
      stpf_pkg::IDX1: row_e = e[1];
      stpf_pkg::IDX2: row_e = e[2];
      default:        row_e = e[0];
    endcase
    unique case (col)
      stpf_pkg::IDX1: sel = row_e[1];
      stpf_pkg::IDX2: sel = row_e[2];
      default:        sel = row_e[0];
    endcase
  end

  assign peak.total  = stpf_pkg::energy_t'(row_sum[0] + row_sum[1] + row_sum[2]);
  assign peak.row    = row;
  assign peak.col    = col;
  assign peak.energy = sel;

endmodule
